FILE: design/tsvma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsvma_pkg
// Shared constants, register indexes and types of the triple sensor vote
// moving average unit.
// ----------------------------------------------------------------------------
package tsvma_pkg;

   localparam int HISTORY_DEPTH_DEF = 30;
   localparam int SAMPLE_BITS_DEF   = 10;

   // calibrated moisture percentage
   localparam int PCT_W     = 7;
   localparam int PCT_FULL  = 100;
   localparam int CAL_SCALE = 100;

   // tolerance reset values
   localparam int MTOL_RESET = 10;
   localparam int LTOL_RESET = 50;

   // vote divisor: pair mean or triple mean
   localparam int VOTE_DIV_W     = 2;
   localparam int PAIR_DIVISOR   = 2;
   localparam int TRIPLE_DIVISOR = 3;

   localparam int NUM_SENSORS = 3;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRY_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRY_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRY_C = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_C = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MTOL  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LTOL  = 3'd7;

   typedef enum logic [2:0] {
      VOTE_NONE,
      VOTE_AB,
      VOTE_AC,
      VOTE_BC,
      VOTE_ALL
   } vote_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAL_LOAD,
      ST_CAL_RUN,
      ST_VOTE_LOAD,
      ST_VOTE_RUN,
      ST_UPDATE,
      ST_AVG_LOAD,
      ST_AVG_RUN,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: design/tsvma_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsvma_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tsvma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: design/tsvma_sdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsvma_sdiv
// Restoring bit-serial divider, one quotient bit per cycle. The caller
// guarantees the quotient fits in QW bits, so the upper dividend bits are
// preloaded into the remainder and only QW steps are run.
// ----------------------------------------------------------------------------
module tsvma_sdiv #(
   parameter int NW = 17,
   parameter int DW = 10,
   parameter int QW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               busy,
   output logic      [QW-1:0] quotient
);

   localparam int CW = $clog2(QW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [NW-1:0] dividend_hi;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   always_comb begin
      dividend_hi = dividend >> QW;
      trial       = {rem_ff, quo_ff[QW-1]};
      diff        = trial - {1'b0, dvs_ff};
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      quo_in      = quo_ff;
      if (load) begin
         cnt_in = CW'(QW);
         rem_in = DW'(dividend_hi);
         quo_in = dividend[QW-1:0];
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CW'(1);
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: design/tsvma_vote.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsvma_vote
// Pairwise tolerance vote of three values. Produces the sum and divisor of
// the selected mean; the division itself runs in a serial divider.
// ----------------------------------------------------------------------------
module tsvma_vote #(
   parameter int W = 10
) (
   input  wire logic [W-1:0]                       val_a,
   input  wire logic [W-1:0]                       val_b,
   input  wire logic [W-1:0]                       val_c,
   input  wire logic [W-1:0]                       tol,
   output logic      [W+1:0]                       dividend,
   output logic      [tsvma_pkg::VOTE_DIV_W-1:0]   divisor
);

   import tsvma_pkg::*;

   logic [W-1:0] gap_ab, gap_ac, gap_bc;
   logic         gt_ab, gt_ac, gt_bc;
   logic         lt_ab, lt_ac, lt_bc;
   vote_type     sel;

   always_comb begin
      gap_ab = (val_a > val_b) ? val_a - val_b : val_b - val_a;
      gap_ac = (val_a > val_c) ? val_a - val_c : val_c - val_a;
      gap_bc = (val_b > val_c) ? val_b - val_c : val_c - val_b;
      gt_ab  = gap_ab > tol;
      gt_ac  = gap_ac > tol;
      gt_bc  = gap_bc > tol;
      lt_ab  = gap_ab < tol;
      lt_ac  = gap_ac < tol;
      lt_bc  = gap_bc < tol;

      if (gt_ab && gt_ac && gt_bc) begin
         sel = VOTE_NONE;
      end else if (lt_ab && gt_ac && gt_bc) begin
         sel = VOTE_AB;
      end else if (gt_ab && lt_ac && gt_bc) begin
         sel = VOTE_AC;
      end else if (gt_ab && gt_ac && lt_bc) begin
         sel = VOTE_BC;
      end else begin
         sel = VOTE_ALL;
      end

      case (sel)
         VOTE_NONE: begin
            dividend = '0;
            divisor  = VOTE_DIV_W'(TRIPLE_DIVISOR);
         end
         VOTE_AB: begin
            dividend = (W+2)'(val_a) + (W+2)'(val_b);
            divisor  = VOTE_DIV_W'(PAIR_DIVISOR);
         end
         VOTE_AC: begin
            dividend = (W+2)'(val_a) + (W+2)'(val_c);
            divisor  = VOTE_DIV_W'(PAIR_DIVISOR);
         end
         VOTE_BC: begin
            dividend = (W+2)'(val_b) + (W+2)'(val_c);
            divisor  = VOTE_DIV_W'(PAIR_DIVISOR);
         end
         default: begin
            dividend = (W+2)'(val_a) + (W+2)'(val_b) + (W+2)'(val_c);
            divisor  = VOTE_DIV_W'(TRIPLE_DIVISOR);
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: design/triple_sensor_vote_moving_average_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triple_sensor_vote_moving_average_unit
// Calibrates and votes three moisture samples, votes three light samples, keeps a
// history ring with running sums and returns the ring means.
// ----------------------------------------------------------------------------
// A request runs through calibration, vote mean and ring mean in the bit-serial
// dividers, each with a load state: 7 calibration steps, SAMPLE_BITS steps of vote
// mean and SAMPLE_BITS steps of ring mean. The result waits while a previous
// response stalls, and no new request is taken until it is loaded for output.
// Reset: registers to their defaults; the history ring reads as zero until
// its first wrap, so no clearing pass is run.
module triple_sensor_vote_moving_average_unit #(
   parameter int HISTORY_DEPTH = tsvma_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLE_BITS   = tsvma_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // requests
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [SAMPLE_BITS-1:0]          req_moist_raw_a,
   input  wire logic [SAMPLE_BITS-1:0]          req_moist_raw_b,
   input  wire logic [SAMPLE_BITS-1:0]          req_moist_raw_c,
   input  wire logic [SAMPLE_BITS-1:0]          req_light_raw_a,
   input  wire logic [SAMPLE_BITS-1:0]          req_light_raw_b,
   input  wire logic [SAMPLE_BITS-1:0]          req_light_raw_c,
   input  wire logic                            req_water_in,
   // results
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [tsvma_pkg::PCT_W-1:0]     rsp_moisture_average,
   output logic      [SAMPLE_BITS-1:0]          rsp_light_average,
   output logic                                 rsp_water_flag,
   // configuration
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tsvma_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [SAMPLE_BITS-1:0]          csr_wdata
);

   import tsvma_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int IW    = $clog2(HISTORY_DEPTH);
   localparam int CNW   = SB + PCT_W;
   localparam int MSW   = $clog2(PCT_FULL * HISTORY_DEPTH + 1);
   localparam int LSW   = $clog2(((2 ** SB) - 1) * HISTORY_DEPTH + 1);
   localparam int ADW   = $clog2(HISTORY_DEPTH + 1);
   localparam int RAM_W = PCT_W + SB;

   // configuration registers
   logic [SB-1:0]    dry_ff [NUM_SENSORS];
   logic [SB-1:0]    wet_ff [NUM_SENSORS];
   logic [PCT_W-1:0] mtol_ff;
   logic [SB-1:0]    ltol_ff;
   logic             csr_we;

   // captured request
   logic [SB-1:0]    m_raw_ff [NUM_SENSORS];
   logic [SB-1:0]    l_raw_ff [NUM_SENSORS];
   logic             water_ff;
   logic             req_take;

   // control
   state_type        state_ff, state_in;
   logic             out_load;

   // calibration
   logic [NUM_SENSORS-1:0] cal_zero_ff, cal_full_ff;
   logic [NUM_SENSORS-1:0] cal_zero, cal_full;
   logic [NUM_SENSORS-1:0] cal_busy;
   logic [CNW-1:0]         cal_dvd  [NUM_SENSORS];
   logic [SB-1:0]          cal_span [NUM_SENSORS];
   logic [PCT_W-1:0]       cal_q    [NUM_SENSORS];
   logic [PCT_W-1:0]       pct      [NUM_SENSORS];

   // vote
   logic [PCT_W+1:0]       m_vdvd;
   logic [VOTE_DIV_W-1:0]  m_vdvs;
   logic [SB+1:0]          l_vdvd;
   logic [VOTE_DIV_W-1:0]  l_vdvs;
   logic                   m_vbusy, l_vbusy;
   logic [PCT_W-1:0]       m_vote;
   logic [SB-1:0]          l_vote;

   // history ring and sums
   logic [IW-1:0]          idx_ff;
   logic                   wrap_ff;
   logic [MSW-1:0]         m_sum_ff, m_sum_in;
   logic [LSW-1:0]         l_sum_ff, l_sum_in;
   logic [RAM_W-1:0]       ram_rdata;
   logic [PCT_W-1:0]       m_old;
   logic [SB-1:0]          l_old;
   logic                   ring_we;

   // averages
   logic                   m_abusy, l_abusy;
   logic [PCT_W-1:0]       m_avg;
   logic [SB-1:0]          l_avg;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]       rsp_m_ff;
   logic [SB-1:0]          rsp_l_ff;
   logic                   rsp_w_ff;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            dry_ff[i] <= '1;
            wet_ff[i] <= '0;
         end
         mtol_ff <= PCT_W'(MTOL_RESET);
         ltol_ff <= SB'(LTOL_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_DRY_A: dry_ff[0] <= csr_wdata;
            CSR_WET_A: wet_ff[0] <= csr_wdata;
            CSR_DRY_B: dry_ff[1] <= csr_wdata;
            CSR_WET_B: wet_ff[1] <= csr_wdata;
            CSR_DRY_C: dry_ff[2] <= csr_wdata;
            CSR_WET_C: wet_ff[2] <= csr_wdata;
            CSR_MTOL:  mtol_ff   <= csr_wdata[PCT_W-1:0];
            CSR_LTOL:  ltol_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CAL_LOAD;
            end
         end
         ST_CAL_LOAD:  state_in = ST_CAL_RUN;
         ST_CAL_RUN: begin
            if (cal_busy == '0) begin
               state_in = ST_VOTE_LOAD;
            end
         end
         ST_VOTE_LOAD: state_in = ST_VOTE_RUN;
         ST_VOTE_RUN: begin
            if (!m_vbusy && !l_vbusy) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE:    state_in = ST_AVG_LOAD;
         ST_AVG_LOAD:  state_in = ST_AVG_RUN;
         ST_AVG_RUN: begin
            if (!m_abusy && !l_abusy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         m_raw_ff[0] <= req_moist_raw_a;
         m_raw_ff[1] <= req_moist_raw_b;
         m_raw_ff[2] <= req_moist_raw_c;
         l_raw_ff[0] <= req_light_raw_a;
         l_raw_ff[1] <= req_light_raw_b;
         l_raw_ff[2] <= req_light_raw_c;
         water_ff    <= req_water_in;
      end
   end

   // ---------------------------------------------------------------------
   // calibration: (dry - raw) * 100 / (dry - wet), one divider per sensor
   // ---------------------------------------------------------------------
   for (genvar s = 0; s < NUM_SENSORS; s++) begin : g_cal
      assign cal_zero[s] = (dry_ff[s] <= wet_ff[s]) || (m_raw_ff[s] >= dry_ff[s]);
      assign cal_full[s] = (m_raw_ff[s] <= wet_ff[s]);
      assign cal_span[s] = dry_ff[s] - wet_ff[s];
      assign cal_dvd[s]  = CNW'(dry_ff[s] - m_raw_ff[s]) * CNW'(CAL_SCALE);

      tsvma_sdiv #(
         .NW (CNW),
         .DW (SB),
         .QW (PCT_W)
      ) u_cal_div (
         .clock    (clock),
         .reset    (reset),
         .load     (state_ff == ST_CAL_LOAD),
         .dividend (cal_dvd[s]),
         .divisor  (cal_span[s]),
         .busy     (cal_busy[s]),
         .quotient (cal_q[s])
      );

      // out of range samples bypass the divider result
      assign pct[s] = cal_zero_ff[s] ? '0 :
                      cal_full_ff[s] ? PCT_W'(PCT_FULL) : cal_q[s];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CAL_LOAD) begin
         cal_zero_ff <= cal_zero;
         cal_full_ff <= cal_full;
      end
   end

   // ---------------------------------------------------------------------
   // vote and mean of the agreeing values
   // ---------------------------------------------------------------------
   tsvma_vote #(.W(PCT_W)) u_m_vote (
      .val_a    (pct[0]),
      .val_b    (pct[1]),
      .val_c    (pct[2]),
      .tol      (mtol_ff),
      .dividend (m_vdvd),
      .divisor  (m_vdvs)
   );

   tsvma_vote #(.W(SB)) u_l_vote (
      .val_a    (l_raw_ff[0]),
      .val_b    (l_raw_ff[1]),
      .val_c    (l_raw_ff[2]),
      .tol      (ltol_ff),
      .dividend (l_vdvd),
      .divisor  (l_vdvs)
   );

   tsvma_sdiv #(
      .NW (PCT_W + 2),
      .DW (VOTE_DIV_W),
      .QW (PCT_W)
   ) u_m_vdiv (
      .clock    (clock),
      .reset    (reset),
      .load     (state_ff == ST_VOTE_LOAD),
      .dividend (m_vdvd),
      .divisor  (m_vdvs),
      .busy     (m_vbusy),
      .quotient (m_vote)
   );

   tsvma_sdiv #(
      .NW (SB + 2),
      .DW (VOTE_DIV_W),
      .QW (SB)
   ) u_l_vdiv (
      .clock    (clock),
      .reset    (reset),
      .load     (state_ff == ST_VOTE_LOAD),
      .dividend (l_vdvd),
      .divisor  (l_vdvs),
      .busy     (l_vbusy),
      .quotient (l_vote)
   );

   // ---------------------------------------------------------------------
   // history ring; entries read as zero until the first wrap
   // ---------------------------------------------------------------------
   assign ring_we = (state_ff == ST_UPDATE);

   tsvma_ram #(
      .WIDTH (RAM_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (idx_ff),
      .wr_data ({m_vote, l_vote}),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign m_old    = wrap_ff ? ram_rdata[RAM_W-1:SB] : '0;
   assign l_old    = wrap_ff ? ram_rdata[SB-1:0]     : '0;
   assign m_sum_in = m_sum_ff - MSW'(m_old) + MSW'(m_vote);
   assign l_sum_in = l_sum_ff - LSW'(l_old) + LSW'(l_vote);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         wrap_ff  <= 1'b0;
         m_sum_ff <= '0;
         l_sum_ff <= '0;
      end else if (ring_we) begin
         m_sum_ff <= m_sum_in;
         l_sum_ff <= l_sum_in;
         if (idx_ff == IW'(HISTORY_DEPTH - 1)) begin
            idx_ff  <= '0;
            wrap_ff <= 1'b1;
         end else begin
            idx_ff <= idx_ff + IW'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // ring means
   // ---------------------------------------------------------------------
   tsvma_sdiv #(
      .NW (MSW),
      .DW (ADW),
      .QW (PCT_W)
   ) u_m_adiv (
      .clock    (clock),
      .reset    (reset),
      .load     (state_ff == ST_AVG_LOAD),
      .dividend (m_sum_ff),
      .divisor  (ADW'(HISTORY_DEPTH)),
      .busy     (m_abusy),
      .quotient (m_avg)
   );

   tsvma_sdiv #(
      .NW (LSW),
      .DW (ADW),
      .QW (SB)
   ) u_l_adiv (
      .clock    (clock),
      .reset    (reset),
      .load     (state_ff == ST_AVG_LOAD),
      .dividend (l_sum_ff),
      .divisor  (ADW'(HISTORY_DEPTH)),
      .busy     (l_abusy),
      .quotient (l_avg)
   );

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_m_ff <= m_avg;
         rsp_l_ff <= l_avg;
         rsp_w_ff <= water_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_moisture_average = rsp_m_ff;
   assign rsp_light_average    = rsp_l_ff;
   assign rsp_water_flag       = rsp_w_ff;

endmodule
`default_nettype wire

FILE: bench/triple_sensor_vote_moving_average_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_sensor_vote_moving_average_unit_tb
// Drives sensor sample requests and calibration writes into the vote and
// moving average unit. Each response is checked against a behavioral model of
// the calibration, pairwise vote and 30-deep history ring.
// ----------------------------------------------------------------------------
module triple_sensor_vote_moving_average_unit_tb;
   import tsvma_pkg::*;

   localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
   localparam int DEPTH           = HISTORY_DEPTH_DEF;
   localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 4;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 219;
   localparam int MAX_GAP         = 45;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 1500000;

   localparam int IDLE_PCT  [4] = '{0, 80, 0, 34};
   localparam int STALL_PCT [4] = '{0, 0, 80, 34};

   typedef struct packed {
      logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] moist;
      logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] light;
      logic                                 water;
   } sample_type;

   typedef struct packed {
      logic [PCT_W-1:0]    moisture;
      logic [SAMPLE_W-1:0] light;
      logic                water;
   } reading_type;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_moist_raw_a    = '0;
   logic [SAMPLE_W-1:0]   req_moist_raw_b    = '0;
   logic [SAMPLE_W-1:0]   req_moist_raw_c    = '0;
   logic [SAMPLE_W-1:0]   req_light_raw_a    = '0;
   logic [SAMPLE_W-1:0]   req_light_raw_b    = '0;
   logic [SAMPLE_W-1:0]   req_light_raw_c    = '0;
   logic                  req_water_in       = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic [PCT_W-1:0]      rsp_moisture_average;
   logic [SAMPLE_W-1:0]   rsp_light_average;
   logic                  rsp_water_flag;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index          = '0;
   logic [SAMPLE_W-1:0]   csr_wdata          = '0;

   triple_sensor_vote_moving_average_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_moist_raw_a      (req_moist_raw_a),
      .req_moist_raw_b      (req_moist_raw_b),
      .req_moist_raw_c      (req_moist_raw_c),
      .req_light_raw_a      (req_light_raw_a),
      .req_light_raw_b      (req_light_raw_b),
      .req_light_raw_c      (req_light_raw_c),
      .req_water_in         (req_water_in),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_moisture_average (rsp_moisture_average),
      .rsp_light_average    (rsp_light_average),
      .rsp_water_flag       (rsp_water_flag),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // model copy of configuration and history
   int dry_raw [NUM_SENSORS] = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
   int wet_raw [NUM_SENSORS] = '{0, 0, 0};
   int moist_tol   = MTOL_RESET;
   int light_tol   = LTOL_RESET;
   int moist_ring [DEPTH];
   int light_ring [DEPTH];
   int moist_total = 0;
   int light_total = 0;
   int ring_slot   = 0;

   reading_type expected_readings [$];
   int fail_count         = 0;
   int cycle_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   function automatic int abs_gap(int x, int y);
      return (x > y) ? x - y : y - x;
   endfunction

   function automatic int percent_of(int raw, int dry, int wet);
      if (dry <= wet) return 0;
      if (raw >= dry) return 0;
      if (raw <= wet) return PCT_FULL;
      return ((dry - raw) * CAL_SCALE) / (dry - wet);
   endfunction

   function automatic int voted_value(int a, int b, int c, int t);
      int ab, ac, bc;
      vote_type kind;
      ab = abs_gap(a, b);
      ac = abs_gap(a, c);
      bc = abs_gap(b, c);
      // strict compare on the lone pair; a gap equal to t falls to the mean
      if (ab > t && ac > t && bc > t)      kind = VOTE_NONE;
      else if (ab < t && ac > t && bc > t) kind = VOTE_AB;
      else if (ab > t && ac < t && bc > t) kind = VOTE_AC;
      else if (ab > t && ac > t && bc < t) kind = VOTE_BC;
      else                                 kind = VOTE_ALL;
      case (kind)
         VOTE_NONE: return 0;
         VOTE_AB:   return (a + b) / PAIR_DIVISOR;
         VOTE_AC:   return (a + c) / PAIR_DIVISOR;
         VOTE_BC:   return (b + c) / PAIR_DIVISOR;
         default:   return (a + b + c) / TRIPLE_DIVISOR;
      endcase
   endfunction

   function automatic reading_type advance_history(sample_type s);
      int pct [NUM_SENSORS];
      int mv, lv;
      reading_type r;
      for (int i = 0; i < NUM_SENSORS; i++)
         pct[i] = percent_of(int'(s.moist[i]), dry_raw[i], wet_raw[i]);
      mv = voted_value(pct[0], pct[1], pct[2], moist_tol);
      lv = voted_value(int'(s.light[0]), int'(s.light[1]), int'(s.light[2]), light_tol);
      moist_total = moist_total - moist_ring[ring_slot] + mv;
      light_total = light_total - light_ring[ring_slot] + lv;
      moist_ring[ring_slot] = mv;
      light_ring[ring_slot] = lv;
      ring_slot = (ring_slot + 1 >= DEPTH) ? 0 : ring_slot + 1;
      r.moisture = PCT_W'(moist_total / DEPTH);
      r.light    = SAMPLE_W'(light_total / DEPTH);
      r.water    = s.water;
      return r;
   endfunction

   function automatic sample_type make_sample(int ma, int mb, int mc, int la, int lb, int lc,
                                              bit w);
      sample_type s;
      s.moist[0] = SAMPLE_W'(ma);
      s.moist[1] = SAMPLE_W'(mb);
      s.moist[2] = SAMPLE_W'(mc);
      s.light[0] = SAMPLE_W'(la);
      s.light[1] = SAMPLE_W'(lb);
      s.light[2] = SAMPLE_W'(lc);
      s.water    = w;
      return s;
   endfunction

   // three readings: mostly clustered, some with one outlier, some noise
   function automatic logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] sensor_triple(int spread);
      logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] v;
      int base, odd, mode, x;
      base = int'($urandom_range(0, SAMPLE_MAX));
      mode = int'($urandom_range(0, 9));
      odd  = int'($urandom_range(0, NUM_SENSORS - 1));
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (mode <= 6) begin
            x = base + int'($urandom_range(0, 2 * spread)) - spread;
            if (mode >= 4 && i == odd)
               x = (base + (SAMPLE_MAX + 1) / 2 + int'($urandom_range(0, spread)))
                   % (SAMPLE_MAX + 1);
            if (x < 0) x = 0;
            if (x > SAMPLE_MAX) x = SAMPLE_MAX;
         end else if (mode <= 8) begin
            x = int'($urandom_range(0, SAMPLE_MAX));
         end else begin
            x = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : 0;
         end
         v[i] = SAMPLE_W'(x);
      end
      return v;
   endfunction

   task automatic report_mismatch(string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // request valid is dropped first so an accepted request is not offered again
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_readings.size() != 0);
   endtask

   task automatic send_request(sample_type s);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_moist_raw_a <= s.moist[0];
      req_moist_raw_b <= s.moist[1];
      req_moist_raw_c <= s.moist[2];
      req_light_raw_a <= s.light[0];
      req_light_raw_b <= s.light[1];
      req_light_raw_c <= s.light[2];
      req_water_in    <= s.water;
      do @(posedge clock); while (!req_ready);
      expected_readings.push_back(advance_history(s));
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DRY_A: dry_raw[0] = value;
         CSR_WET_A: wet_raw[0] = value;
         CSR_DRY_B: dry_raw[1] = value;
         CSR_WET_B: wet_raw[1] = value;
         CSR_DRY_C: dry_raw[2] = value;
         CSR_WET_C: wet_raw[2] = value;
         CSR_MTOL:  moist_tol  = value[PCT_W-1:0];
         CSR_LTOL:  light_tol  = value;
         default: ;
      endcase
   endtask

   task automatic set_calibration(int da, int wa, int db, int wb, int dc, int wc);
      write_register(CSR_DRY_A, SAMPLE_W'(da));
      write_register(CSR_WET_A, SAMPLE_W'(wa));
      write_register(CSR_DRY_B, SAMPLE_W'(db));
      write_register(CSR_WET_B, SAMPLE_W'(wb));
      write_register(CSR_DRY_C, SAMPLE_W'(dc));
      write_register(CSR_WET_C, SAMPLE_W'(wc));
   endtask

   task automatic set_tolerances(int mt, int lt);
      write_register(CSR_MTOL, SAMPLE_W'(mt));
      write_register(CSR_LTOL, SAMPLE_W'(lt));
   endtask

   // dry 100 / wet 0 makes the percentage 100 - raw
   task automatic test_vote_selection();
      set_calibration(100, 0, 100, 0, 100, 0);
      set_tolerances(MTOL_RESET, LTOL_RESET);
      send_request(make_sample(10, 40, 70, 0, 200, 400, 1'b1));
      send_request(make_sample(10, 15, 70, 100, 120, 500, 1'b0));
      send_request(make_sample(10, 60, 15, 100, 500, 130, 1'b1));
      send_request(make_sample(10, 50, 55, 900, 100, 140, 1'b0));
      send_request(make_sample(20, 22, 25, 300, 310, 320, 1'b1));
      // gaps equal to the tolerance
      send_request(make_sample(20, 30, 60, 0, 50, SAMPLE_MAX, 1'b0));
      send_request(make_sample(0, SAMPLE_MAX, 100, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1));
      send_request(make_sample(0, 0, 0, 0, 0, 0, 1'b0));
   endtask

   task automatic test_calibration_limits();
      // a: dry == wet, b: dry < wet, c: full span
      set_calibration(500, 500, 200, 800, SAMPLE_MAX, 0);
      send_request(make_sample(500, 500, 500, 10, 20, 30, 1'b1));
      send_request(make_sample(0, SAMPLE_MAX, 512, 600, 610, 990, 1'b0));
      send_request(make_sample(SAMPLE_MAX, 0, SAMPLE_MAX, 5, 700, 720, 1'b1));
      // narrow spans and samples on or beyond the calibration points
      set_calibration(SAMPLE_MAX, SAMPLE_MAX - 1, 1, 0, 700, 300);
      send_request(make_sample(SAMPLE_MAX, SAMPLE_MAX - 1, 700, 1, 2, 3, 1'b0));
      send_request(make_sample(SAMPLE_MAX - 1, 0, 300, 400, 450, 499, 1'b1));
      send_request(make_sample(0, 1, 699, 800, 60, 820, 1'b0));
      send_request(make_sample(SAMPLE_MAX, SAMPLE_MAX, 500, 1000, 1023, 1010, 1'b1));
   endtask

   task automatic test_tolerance_limits();
      set_calibration(SAMPLE_MAX, 0, SAMPLE_MAX, 0, SAMPLE_MAX, 0);
      // moisture tolerance truncates to 127: every pair agrees
      set_tolerances(SAMPLE_MAX, SAMPLE_MAX);
      send_request(make_sample(0, SAMPLE_MAX, 512, 0, SAMPLE_MAX, 500, 1'b1));
      set_tolerances(0, 0);
      send_request(make_sample(300, 300, 300, 7, 7, 7, 1'b0));
      send_request(make_sample(100, 400, 900, 1, 2, 4, 1'b1));
      send_request(make_sample(250, 250, 800, 64, 64, 900, 1'b0));
   endtask

   task automatic configure_phase(int p);
      int dry [NUM_SENSORS];
      int wet [NUM_SENSORS];
      int mt, lt;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         dry[i] = int'($urandom_range(512, SAMPLE_MAX));
         wet[i] = int'($urandom_range(0, 511));
      end
      mt = int'($urandom_range(0, SAMPLE_MAX));
      lt = int'($urandom_range(0, 255));
      case (p)
         0: begin
            dry = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
            wet = '{0, 0, 0};
            mt  = MTOL_RESET;
            lt  = LTOL_RESET;
         end
         1: begin
            mt = 0;
            lt = 0;
         end
         2: begin
            mt = SAMPLE_MAX;
            lt = SAMPLE_MAX;
         end
         3: begin
            dry[0] = wet[0];
            dry[1] = wet[1] / 2;
            dry[2] = SAMPLE_MAX;
            wet[2] = 0;
         end
         default: ;
      endcase
      set_calibration(dry[0], wet[0], dry[1], wet[1], dry[2], wet[2]);
      set_tolerances(mt, lt);
   endtask

   task automatic test_random_phases();
      sample_type s;
      int spread;
      for (int p = 0; p < NUM_PHASES; p++) begin
         configure_phase(p);
         sender_idle_pct    = IDLE_PCT[p % 4];
         receiver_stall_pct = STALL_PCT[p % 4];
         // raw spread that roughly maps onto the moisture tolerance
         if (dry_raw[0] > wet_raw[0])
            spread = (dry_raw[0] - wet_raw[0]) * moist_tol / CAL_SCALE + 1;
         else
            spread = 16;
         if (spread > SAMPLE_MAX) spread = SAMPLE_MAX;
         repeat (ITEMS_PER_PHASE) begin
            // occasionally hold requests until the unit has emptied out
            if ($urandom_range(0, 49) == 0)
               wait_drained();
            s.moist = sensor_triple(spread);
            s.light = sensor_triple((light_tol < SAMPLE_MAX) ? light_tol + 1 : SAMPLE_MAX);
            s.water = 1'($urandom_range(0, 1));
            send_request(s);
         end
      end
   endtask

   always @(posedge clock) begin : result_monitor
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected response moisture=%0d light=%0d water=%0b",
                                      rsp_moisture_average, rsp_light_average,
                                      rsp_water_flag));
         end else begin
            want = expected_readings.pop_front();
            if (rsp_moisture_average !== want.moisture)
               report_mismatch($sformatf("moisture_average got %0d want %0d",
                                         rsp_moisture_average, want.moisture));
            if (rsp_light_average !== want.light)
               report_mismatch($sformatf("light_average got %0d want %0d",
                                         rsp_light_average, want.light));
            if (rsp_water_flag !== want.water)
               report_mismatch($sformatf("water flag got %0b want %0b",
                                         rsp_water_flag, want.water));
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_vote_selection();
      test_calibration_limits();
      test_tolerance_limits();
      test_random_phases();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
